[rtl/sdtc_pkg.sv]
// shared constants and types of the strip degenerate triangle check
package sdtc_pkg;

  // configuration port
  localparam int APB_ADDR_W = 4;
  localparam int APB_DATA_W = 64;
  localparam int REG_IDX_W  = APB_ADDR_W - 3;
  localparam logic [REG_IDX_W-1:0] REG_AREA_THRESHOLD = '0;

  localparam int THRESH_W = 64;

  // input tuser layout
  localparam int IN_USER_W        = 2;
  localparam int USER_STRIP_START = 0;
  localparam int USER_QUERY_START = 1;

  // output tdata layout
  localparam int OUT_DATA_W = 8;

  typedef struct packed {
    logic any_nondegenerate;
    logic triangle_nondegenerate;
  } res_t;

endpackage

[rtl/sdtc_front.sv]
// front end: vertex window, strip tracking and edge vector forming
module sdtc_front #(
  parameter int COORD_BITS = 16
) (
  input  logic                                               clk_i,
  input  logic                                               rst_ni,
  input  logic                                               valid_i,
  output logic                                               ready_o,
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]                  data_i,
  input  logic [sdtc_pkg::IN_USER_W-1:0]                     user_i,
  output logic                                               push_valid_o,
  input  logic                                               push_ready_i,
  output logic [6*(COORD_BITS+1):0]                          push_data_o
);
  import sdtc_pkg::*;

  localparam int D = COORD_BITS + 1;
  localparam logic [1:0] FILL_FULL = 2'd2;

  logic signed [COORD_BITS-1:0] older_q [3];
  logic signed [COORD_BITS-1:0] newer_q [3];
  logic signed [COORD_BITS-1:0] cur     [3];
  logic signed [D-1:0]          ab      [3];
  logic signed [D-1:0]          ac      [3];
  logic [1:0] fill_q, fill_d, fill_eff;
  logic       pend_clr_q, pend_clr_d;
  logic       accept, has_tri, clr;

  assign ready_o      = push_ready_i;
  assign accept       = valid_i && push_ready_i;
  assign fill_eff     = user_i[USER_STRIP_START] ? 2'd0 : fill_q;
  assign has_tri      = (fill_eff == FILL_FULL);
  assign clr          = user_i[USER_QUERY_START] || pend_clr_q;
  assign push_valid_o = valid_i && has_tri;

  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cur[k] = data_i[k*COORD_BITS +: COORD_BITS];
      ab[k]  = D'(newer_q[k]) - D'(older_q[k]);
      ac[k]  = D'(cur[k]) - D'(older_q[k]);
      push_data_o[k*D +: D]     = ab[k];
      push_data_o[(k+3)*D +: D] = ac[k];
    end
    push_data_o[6*D] = clr;
  end

  // a query start on a vertex without a triangle is carried to the next one
  always_comb begin
    fill_d     = fill_q;
    pend_clr_d = pend_clr_q;
    if (accept) begin
      fill_d     = has_tri ? FILL_FULL : fill_eff + 2'd1;
      pend_clr_d = has_tri ? 1'b0 : clr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q     <= '0;
      pend_clr_q <= 1'b0;
    end else begin
      fill_q     <= fill_d;
      pend_clr_q <= pend_clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int k = 0; k < 3; k++) begin
        older_q[k] <= newer_q[k];
        newer_q[k] <= cur[k];
      end
    end
  end

endmodule

[rtl/sdtc_queue.sv]
// short fifo between front end and back end
module sdtc_queue #(
  parameter int DATA_W = 103,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              wr_valid_i,
  output logic              wr_ready_o,
  input  logic [DATA_W-1:0] wr_data_i,
  output logic              rd_valid_o,
  input  logic              rd_ready_i,
  output logic [DATA_W-1:0] rd_data_o
);
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  cnt_q;
  logic              do_wr, do_rd;

  assign wr_ready_o = (cnt_q != CNT_W'(DEPTH));
  assign rd_valid_o = (cnt_q != '0);
  assign rd_data_o  = mem_q[rd_ptr_q];
  assign do_wr      = wr_valid_i && wr_ready_o;
  assign do_rd      = rd_valid_o && rd_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

[rtl/sdtc_back.sv]
// back end: cross product and squared magnitude on one shared multiplier
module sdtc_back #(
  parameter int COORD_BITS = 16
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              q_valid_i,
  output logic                              q_ready_o,
  input  logic [6*(COORD_BITS+1):0]         q_data_i,
  input  logic [sdtc_pkg::THRESH_W-1:0]     thr_i,
  output logic                              res_valid_o,
  input  logic                              res_ready_i,
  output sdtc_pkg::res_t                    res_o
);
  import sdtc_pkg::*;

  localparam int D     = COORD_BITS + 1;      // edge component
  localparam int M     = D + 1;               // multiplier operand
  localparam int P     = 2 * M;               // product
  localparam int C     = 2 * COORD_BITS + 3;  // cross component
  localparam int H     = D;                   // half of a cross magnitude
  localparam int S     = 4 * COORD_BITS + 4;  // sum of squares
  localparam int CMP_W = (S > THRESH_W) ? S : THRESH_W;
  localparam int NSTEP = 15;
  localparam int CNT_W = $clog2(NSTEP + 1);

  // multiplier schedule
  localparam logic [CNT_W-1:0] ST_CR0A = CNT_W'(0);
  localparam logic [CNT_W-1:0] ST_CR0B = CNT_W'(1);
  localparam logic [CNT_W-1:0] ST_CR1A = CNT_W'(2);
  localparam logic [CNT_W-1:0] ST_CR1B = CNT_W'(3);
  localparam logic [CNT_W-1:0] ST_CR2A = CNT_W'(4);
  localparam logic [CNT_W-1:0] ST_CR2B = CNT_W'(5);
  localparam logic [CNT_W-1:0] ST_SQ0L = CNT_W'(6);
  localparam logic [CNT_W-1:0] ST_SQ0M = CNT_W'(7);
  localparam logic [CNT_W-1:0] ST_SQ0H = CNT_W'(8);
  localparam logic [CNT_W-1:0] ST_SQ1L = CNT_W'(9);
  localparam logic [CNT_W-1:0] ST_SQ1M = CNT_W'(10);
  localparam logic [CNT_W-1:0] ST_SQ1H = CNT_W'(11);
  localparam logic [CNT_W-1:0] ST_SQ2L = CNT_W'(12);
  localparam logic [CNT_W-1:0] ST_SQ2M = CNT_W'(13);
  localparam logic [CNT_W-1:0] ST_SQ2H = CNT_W'(14);
  localparam logic [CNT_W-1:0] ST_LAST = CNT_W'(NSTEP);

  typedef enum logic [1:0] {S_IDLE, S_RUN, S_CMP} state_e;

  state_e             state_q, state_d;
  logic [CNT_W-1:0]   cnt_q, cnt_d, tag;
  logic signed [D-1:0] ab_q [3];
  logic signed [D-1:0] ac_q [3];
  logic signed [D-1:0] ab_d [3];
  logic signed [D-1:0] ac_d [3];
  logic signed [C-1:0] cr_q [3];
  logic signed [C-1:0] cr_d [3];
  logic signed [C-1:0] cr_pick;
  logic [C-1:0]        mag_full;
  logic [2*H-1:0]      mag;
  logic [H-1:0]        mag_lo, mag_hi;
  logic signed [M-1:0] op_a, op_b;
  logic signed [P-1:0] prod_q, prod_d;
  logic [S-1:0]        sum_q, sum_d, sq_term;
  logic                found_q, found_d;
  logic                out_vld_q, out_vld_d;
  res_t                out_q, out_d;
  logic                pass, pop;

  assign q_ready_o   = (state_q == S_IDLE);
  assign pop         = q_valid_i && q_ready_o;
  assign res_valid_o = out_vld_q;
  assign res_o       = out_q;
  assign tag         = cnt_q - 1'b1;
  assign pass        = CMP_W'(sum_q) > CMP_W'(thr_i);

  // which cross component is being squared
  always_comb begin
    case (cnt_q)
      ST_SQ1L, ST_SQ1M, ST_SQ1H: cr_pick = cr_q[1];
      ST_SQ2L, ST_SQ2M, ST_SQ2H: cr_pick = cr_q[2];
      default:                   cr_pick = cr_q[0];
    endcase
  end

  assign mag_full = cr_pick[C-1] ? -cr_pick : cr_pick;
  assign mag      = mag_full[2*H-1:0];
  assign mag_lo   = mag[H-1:0];
  assign mag_hi   = mag[2*H-1:H];

  always_comb begin
    case (cnt_q)
      ST_CR0A: begin op_a = M'(ab_q[1]); op_b = M'(ac_q[2]); end
      ST_CR0B: begin op_a = M'(ab_q[2]); op_b = M'(ac_q[1]); end
      ST_CR1A: begin op_a = M'(ab_q[2]); op_b = M'(ac_q[0]); end
      ST_CR1B: begin op_a = M'(ab_q[0]); op_b = M'(ac_q[2]); end
      ST_CR2A: begin op_a = M'(ab_q[0]); op_b = M'(ac_q[1]); end
      ST_CR2B: begin op_a = M'(ab_q[1]); op_b = M'(ac_q[0]); end
      ST_SQ0L, ST_SQ1L, ST_SQ2L: begin
        op_a = $signed({1'b0, mag_lo});
        op_b = $signed({1'b0, mag_lo});
      end
      ST_SQ0M, ST_SQ1M, ST_SQ2M: begin
        op_a = $signed({1'b0, mag_lo});
        op_b = $signed({1'b0, mag_hi});
      end
      ST_SQ0H, ST_SQ1H, ST_SQ2H: begin
        op_a = $signed({1'b0, mag_hi});
        op_b = $signed({1'b0, mag_hi});
      end
      default: begin op_a = '0; op_b = '0; end
    endcase
  end

  assign prod_d  = op_a * op_b;
  assign sq_term = {{(S-P){1'b0}}, prod_q};

  // accumulate the registered product of the previous step
  always_comb begin
    for (int k = 0; k < 3; k++) begin
      cr_d[k] = cr_q[k];
    end
    sum_d = sum_q;
    if (state_q == S_IDLE) begin
      sum_d = '0;
    end else if (state_q == S_RUN && cnt_q != '0) begin
      case (tag)
        ST_CR0A: cr_d[0] = prod_q[C-1:0];
        ST_CR0B: cr_d[0] = cr_q[0] - prod_q[C-1:0];
        ST_CR1A: cr_d[1] = prod_q[C-1:0];
        ST_CR1B: cr_d[1] = cr_q[1] - prod_q[C-1:0];
        ST_CR2A: cr_d[2] = prod_q[C-1:0];
        ST_CR2B: cr_d[2] = cr_q[2] - prod_q[C-1:0];
        ST_SQ0L, ST_SQ1L, ST_SQ2L: sum_d = sum_q + sq_term;
        ST_SQ0M, ST_SQ1M, ST_SQ2M: sum_d = sum_q + (sq_term << (H + 1));
        ST_SQ0H, ST_SQ1H, ST_SQ2H: sum_d = sum_q + (sq_term << (2 * H));
        default: ;
      endcase
    end
  end

  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    found_d   = found_q;
    out_vld_d = out_vld_q && !res_ready_i;
    out_d     = out_q;
    for (int k = 0; k < 3; k++) begin
      ab_d[k] = ab_q[k];
      ac_d[k] = ac_q[k];
    end
    case (state_q)
      S_IDLE: begin
        if (pop) begin
          for (int k = 0; k < 3; k++) begin
            ab_d[k] = q_data_i[k*D +: D];
            ac_d[k] = q_data_i[(k+3)*D +: D];
          end
          if (q_data_i[6*D]) begin
            found_d = 1'b0;
          end
          cnt_d   = '0;
          state_d = S_RUN;
        end
      end
      S_RUN: begin
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == ST_LAST) begin
          state_d = S_CMP;
        end
      end
      S_CMP: begin
        // wait here while the previous word is still held
        if (!out_vld_q || res_ready_i) begin
          out_vld_d                    = 1'b1;
          out_d.triangle_nondegenerate = pass;
          out_d.any_nondegenerate      = found_q || pass;
          found_d                      = found_q || pass;
          state_d                      = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      cnt_q     <= '0;
      found_q   <= 1'b0;
      out_vld_q <= 1'b0;
      out_q     <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      found_q   <= found_d;
      out_vld_q <= out_vld_d;
      out_q     <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      ab_q[k] <= ab_d[k];
      ac_q[k] <= ac_d[k];
      cr_q[k] <= cr_d[k];
    end
    prod_q <= prod_d;
    sum_q  <= sum_d;
  end

  a_start_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> (state_q == S_RUN && cnt_q == '0))
    else $error("back end did not start at step zero");

  a_step_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && cnt_q != ST_LAST) |=>
      (state_q == S_RUN && cnt_q == CNT_W'($past(cnt_q) + 1'b1)))
    else $error("multiplier schedule skipped a step");

  a_hold_cmp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_CMP && out_vld_q && !res_ready_i) |=> state_q == S_CMP)
    else $error("result written over a word not yet taken");

  a_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.triangle_nondegenerate) |-> res_o.any_nondegenerate)
    else $error("sticky flag missing on a passing triangle");

endmodule

[rtl/strip_degenerate_triangle_check_top.sv]
// top level of the strip degenerate triangle check
//
// vertices come in on the s_axis channel, one word per vertex: tdata holds
// pos_x, pos_y, pos_z (COORD_BITS each, signed), tuser holds strip_start and
// query_start. from the third vertex of a strip on, each vertex closes a
// triangle and one word leaves on m_axis with triangle_nondegenerate and
// any_nondegenerate; the first two vertices of a strip give no word.
// area_threshold is written over the apb port at address 0 while idle, a
// rule on the user that the block leaves unchecked. a vertex is taken while
// the queue has room and its triangle is queued; the back end works on one
// triangle at a time: it takes the entry, runs 15 products on one shared
// multiplier, one trailing accumulate and one compare, and takes no new
// entry until its word has left the compare step.
// vertices that close no triangle are not queued but still wait for room.
// a two-entry queue lets vertices arrive while a triangle is worked on;
// a stalled receiver holds the output word, the back end waits at its
// compare step and the queue then fills and drops s_axis_tready.
// reset empties the queue, clears the strip, the sticky flag and the
// threshold, and the stream then counts as a new strip.
module strip_degenerate_triangle_check_top #(
  parameter int COORD_BITS = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  // apb configuration
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [sdtc_pkg::APB_ADDR_W-1:0]     paddr,
  input  logic [sdtc_pkg::APB_DATA_W-1:0]     pwdata,
  output logic [sdtc_pkg::APB_DATA_W-1:0]     prdata,
  output logic                                pready,
  // vertex stream
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // pos_x, pos_y, pos_z, zero pad
  input  logic [((3*COORD_BITS+7)/8)*8-1:0]   s_axis_tdata,
  // strip_start, query_start
  input  logic [sdtc_pkg::IN_USER_W-1:0]      s_axis_tuser,
  // result stream
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // triangle_nondegenerate, any_nondegenerate, zero pad
  output logic [sdtc_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);
  import sdtc_pkg::*;

  localparam int ENTRY_W = 6 * (COORD_BITS + 1) + 1;

  logic [THRESH_W-1:0] thr_q;
  logic                reg_hit;
  logic                push_valid, push_ready;
  logic [ENTRY_W-1:0]  push_data;
  logic                q_valid, q_ready;
  logic [ENTRY_W-1:0]  q_data;
  res_t                res;

  assign pready  = 1'b1;
  assign reg_hit = (paddr[APB_ADDR_W-1:3] == REG_AREA_THRESHOLD);
  assign prdata  = reg_hit ? APB_DATA_W'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= '0;
    end else if (psel && penable && pwrite && pready && reg_hit) begin
      thr_q <= pwdata[THRESH_W-1:0];
    end
  end

  sdtc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (s_axis_tvalid),
    .ready_o      (s_axis_tready),
    .data_i       (s_axis_tdata),
    .user_i       (s_axis_tuser),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_data_o  (push_data)
  );

  sdtc_queue #(
    .DATA_W (ENTRY_W),
    .DEPTH  (2)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_valid_i (push_valid),
    .wr_ready_o (push_ready),
    .wr_data_i  (push_data),
    .rd_valid_o (q_valid),
    .rd_ready_i (q_ready),
    .rd_data_o  (q_data)
  );

  sdtc_back #(
    .COORD_BITS (COORD_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_data_i    (q_data),
    .thr_i       (thr_q),
    .res_valid_o (m_axis_tvalid),
    .res_ready_i (m_axis_tready),
    .res_o       (res)
  );

  assign m_axis_tdata = {{(OUT_DATA_W-2){1'b0}}, res.any_nondegenerate,
                         res.triangle_nondegenerate};

endmodule

[verif/tb_strip_degenerate_triangle_check_top.sv]
// self-checking testbench for the strip degenerate triangle check top level
`timescale 1ns / 1ps

module tb_strip_degenerate_triangle_check_top;
  import sdtc_pkg::*;

  localparam int COORD_BITS     = 16;
  localparam int TDATA_W        = ((3 * COORD_BITS + 7) / 8) * 8;
  localparam int COORD_MAX      = (1 << (COORD_BITS - 1)) - 1;
  localparam int COORD_MIN      = -(1 << (COORD_BITS - 1));
  localparam int PHASE_VERTICES = 245;
  localparam int SETTLE_CYCLES  = 40;
  localparam int RX_HOLD_CYCLES = 300;
  localparam logic [THRESH_W-1:0] THRESH_MAX = '1;

  // expected triangle flags, worked out from the accepted vertex stream
  class triangle_flag_board;
    logic [THRESH_W-1:0]          threshold;
    logic signed [COORD_BITS-1:0] older [3];
    logic signed [COORD_BITS-1:0] newer [3];
    int unsigned                  fill;
    bit                           found;
    res_t                         flags_due [$];
    int                           errors;

    function new();
      threshold = '0;
      fill      = 0;
      found     = 1'b0;
      errors    = 0;
      for (int i = 0; i < 3; i++) begin
        older[i] = '0;
        newer[i] = '0;
      end
    endfunction

    // exact squared length of the cross product, sum of three squares
    function logic [127:0] squared_area(longint cr [3]);
      logic signed [127:0] w;
      logic [127:0]        acc;
      acc = '0;
      for (int i = 0; i < 3; i++) begin
        w   = cr[i];
        acc = acc + w * w;
      end
      return acc;
    endfunction

    function void note_vertex(logic [TDATA_W-1:0] data, logic [IN_USER_W-1:0] user);
      logic signed [COORD_BITS-1:0] cur [3];
      longint ab [3];
      longint ac [3];
      longint cr [3];
      res_t   flags;
      for (int i = 0; i < 3; i++) cur[i] = data[i*COORD_BITS +: COORD_BITS];
      if (user[USER_STRIP_START]) fill = 0;
      if (user[USER_QUERY_START]) found = 1'b0;
      if (fill >= 2) begin
        for (int i = 0; i < 3; i++) begin
          ab[i] = longint'(newer[i]) - longint'(older[i]);
          ac[i] = longint'(cur[i]) - longint'(older[i]);
        end
        cr[0] = ab[1] * ac[2] - ab[2] * ac[1];
        cr[1] = ab[2] * ac[0] - ab[0] * ac[2];
        cr[2] = ab[0] * ac[1] - ab[1] * ac[0];
        flags.triangle_nondegenerate = squared_area(cr) > {64'd0, threshold};
        if (flags.triangle_nondegenerate) found = 1'b1;
        flags.any_nondegenerate = found;
        flags_due = {flags_due, flags};
      end
      older = newer;
      newer = cur;
      if (fill < 2) fill++;
    endfunction

    function void check_word(logic [OUT_DATA_W-1:0] data);
      res_t got;
      res_t want;
      got = data[1:0];
      if (flags_due.size() == 0) begin
        $display("%0t: unexpected word: got tri=%b any=%b, nothing pending",
                 $time, got.triangle_nondegenerate, got.any_nondegenerate);
        errors++;
      end else begin
        want = flags_due.pop_front();
        if (got.triangle_nondegenerate !== want.triangle_nondegenerate) begin
          $display("%0t: triangle_nondegenerate mismatch: expected %b, actual %b",
                   $time, want.triangle_nondegenerate, got.triangle_nondegenerate);
          errors++;
        end
        if (got.any_nondegenerate !== want.any_nondegenerate) begin
          $display("%0t: any_nondegenerate mismatch: expected %b, actual %b",
                   $time, want.any_nondegenerate, got.any_nondegenerate);
          errors++;
        end
      end
    endfunction

    function int pending();
      return flags_due.size();
    endfunction
  endclass

  logic                   clk_i;
  logic                   rst_ni;
  logic                   psel;
  logic                   penable;
  logic                   pwrite;
  logic [APB_ADDR_W-1:0]  paddr;
  logic [APB_DATA_W-1:0]  pwdata;
  logic [APB_DATA_W-1:0]  prdata;
  logic                   pready;
  logic                   s_axis_tvalid;
  logic                   s_axis_tready;
  logic [TDATA_W-1:0]     s_axis_tdata;
  logic [IN_USER_W-1:0]   s_axis_tuser;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready;
  logic [OUT_DATA_W-1:0]  m_axis_tdata;

  triangle_flag_board board = new();
  bit calm;
  bit hold_rx;
  int older_sent [3];
  int newer_sent [3];

  strip_degenerate_triangle_check_top #(
    .COORD_BITS(COORD_BITS)
  ) dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  initial begin
    #2_000_000;
    $display("** strip_degenerate_triangle_check_top: FAILED **");
    $finish;
  end

  // receiver: random stall bursts, one long hold-off on request
  initial begin
    m_axis_tready = 1'b0;
    wait (rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_rx) begin
        m_axis_tready = 1'b0;
        repeat (RX_HOLD_CYCLES) @(negedge clk_i);
        hold_rx       = 1'b0;
        m_axis_tready = 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        m_axis_tready = 1'b0;
        repeat ($urandom_range(1, 12) - 1) @(negedge clk_i);
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) board.check_word(m_axis_tdata);
  end

  task automatic send_vertex(input int pos [3], input bit strip, input bit query);
    @(negedge clk_i);
    if (!calm && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
    end
    for (int i = 0; i < 3; i++) s_axis_tdata[i*COORD_BITS +: COORD_BITS] = pos[i][COORD_BITS-1:0];
    s_axis_tuser                   = '0;
    s_axis_tuser[USER_STRIP_START] = strip;
    s_axis_tuser[USER_QUERY_START] = query;
    s_axis_tvalid                  = 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    board.note_vertex(s_axis_tdata, s_axis_tuser);
    older_sent = newer_sent;
    newer_sent = pos;
  endtask

  task automatic wait_drained();
    while (board.pending() != 0) @(posedge clk_i);
  endtask

  task automatic apb_access(input bit wr, input logic [APB_DATA_W-1:0] wdata,
                            output logic [APB_DATA_W-1:0] rdata);
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    psel          = 1'b1;
    penable       = 1'b0;
    pwrite        = wr;
    paddr         = {REG_AREA_THRESHOLD, 3'b000};
    pwdata        = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // only while idle: every word in, then time for vertices that close nothing
  task automatic reprogram_threshold(input logic [THRESH_W-1:0] value);
    logic [APB_DATA_W-1:0] rdata;
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    apb_access(1'b1, value, rdata);
    board.threshold = value;
    apb_access(1'b0, '0, rdata);
    if (rdata !== value) begin
      $display("%0t: area_threshold readback mismatch: expected %h, actual %h",
               $time, value, rdata);
      board.errors++;
    end
  endtask

  task automatic send_strip(input int len, input bit fresh, input int scale);
    int  pos [3];
    int  span;
    bit  fits;
    span = 1 << scale;
    for (int n = 0; n < len; n++) begin
      case ($urandom_range(0, 9))
        0: pos = older_sent;
        1: pos = newer_sent;
        2: begin
          // next point on the line through the last two
          fits = 1'b1;
          for (int i = 0; i < 3; i++) begin
            pos[i] = 2 * newer_sent[i] - older_sent[i];
            if (pos[i] > COORD_MAX || pos[i] < COORD_MIN) fits = 1'b0;
          end
          if (!fits) pos = newer_sent;
        end
        3: begin
          for (int i = 0; i < 3; i++) begin
            case ($urandom_range(0, 3))
              0: pos[i] = COORD_MIN;
              1: pos[i] = COORD_MAX;
              2: pos[i] = 0;
              default: pos[i] = -1;
            endcase
          end
        end
        4, 5: for (int i = 0; i < 3; i++) pos[i] = $urandom_range(0, 65535) - 32768;
        default: for (int i = 0; i < 3; i++) pos[i] = $urandom_range(0, 2 * span) - span;
      endcase
      send_vertex(pos, fresh && n == 0, $urandom_range(0, 11) == 0);
    end
  endtask

  initial begin
    logic [THRESH_W-1:0] thr;
    int                  sent;
    int                  len;
    calm          = 1'b0;
    hold_rx       = 1'b0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    older_sent    = '{0, 0, 0};
    newer_sent    = '{0, 0, 0};
    rst_ni        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // threshold still at reset: stream before any strip start counts as a strip
    send_vertex('{0, 0, 0}, 1'b0, 1'b0);
    send_vertex('{256, 0, 0}, 1'b0, 1'b0);
    send_vertex('{0, 256, 0}, 1'b0, 1'b0);
    // repeated vertex with a query start: zero area, sticky flag cleared
    send_vertex('{0, 256, 0}, 1'b0, 1'b1);
    // largest triangles the coordinates allow
    send_vertex('{COORD_MIN, COORD_MIN, COORD_MIN}, 1'b1, 1'b0);
    send_vertex('{COORD_MAX, COORD_MIN, COORD_MAX}, 1'b0, 1'b0);
    send_vertex('{COORD_MIN, COORD_MAX, COORD_MAX}, 1'b0, 1'b0);
    send_vertex('{COORD_MAX, COORD_MAX, COORD_MIN}, 1'b0, 1'b0);
    // query start on a vertex that closes no triangle, then degenerate only
    send_vertex('{5, 5, 5}, 1'b1, 1'b1);
    send_vertex('{5, 5, 5}, 1'b0, 1'b0);
    send_vertex('{5, 5, 5}, 1'b0, 1'b0);
    // strips cut short before a triangle
    send_vertex('{-1, -1, -1}, 1'b1, 1'b0);
    send_vertex('{100, -7, 3}, 1'b1, 1'b0);
    send_vertex('{COORD_MAX, 0, 0}, 1'b0, 1'b0);
    send_vertex('{1, 2, 3}, 1'b1, 1'b0);
    // smallest nonzero area
    send_vertex('{0, 0, 0}, 1'b1, 1'b1);
    send_vertex('{1, 0, 0}, 1'b0, 1'b0);
    send_vertex('{0, 1, 0}, 1'b0, 1'b0);

    reprogram_threshold(THRESH_MAX);
    send_vertex('{COORD_MIN, COORD_MIN, COORD_MIN}, 1'b1, 1'b1);
    send_vertex('{COORD_MAX, COORD_MIN, COORD_MAX}, 1'b0, 1'b0);
    send_vertex('{COORD_MIN, COORD_MAX, COORD_MAX}, 1'b0, 1'b0);
    send_vertex('{0, 0, 0}, 1'b1, 1'b1);
    send_vertex('{1, 0, 0}, 1'b0, 1'b0);
    send_vertex('{0, 1, 0}, 1'b0, 1'b0);

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: thr = '0;
        1: thr = 64'd1;
        3: thr = THRESH_MAX;
        default: thr = {$urandom, $urandom} >> $urandom_range(8, 63);
      endcase
      reprogram_threshold(thr);
      if (phase == 2) hold_rx = 1'b1;
      if (phase == 5) calm = 1'b1;
      sent = 0;
      while (sent < PHASE_VERTICES) begin
        if (phase == 4 && sent >= PHASE_VERTICES / 2 && sent < PHASE_VERTICES / 2 + 20) begin
          // sender pause until every word has come back
          @(negedge clk_i);
          s_axis_tvalid = 1'b0;
          wait_drained();
        end
        case ($urandom_range(0, 19))
          0, 1: len = $urandom_range(1, 2);
          2:    len = $urandom_range(1, 4);
          default: len = $urandom_range(3, 16);
        endcase
        send_strip(len, $urandom_range(0, 19) != 2, $urandom_range(0, 14));
        sent += len;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    wait_drained();
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (board.pending() != 0) $display("%0t: %0d words never arrived", $time, board.pending());
    if (board.errors == 0 && board.pending() == 0) begin
      $display("** strip_degenerate_triangle_check_top: PASSED **");
    end else begin
      $display("** strip_degenerate_triangle_check_top: FAILED **");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/sdtc_pkg.sv
rtl/sdtc_front.sv
rtl/sdtc_queue.sv
rtl/sdtc_back.sv
rtl/strip_degenerate_triangle_check_top.sv
verif/tb_strip_degenerate_triangle_check_top.sv
